// ===== sv/xcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcd_pkg: shared types and constants of the command deframer
// op codes, item kinds, poll status codes, config indexes and reset values
// ----------------------------------------------------------------------------
package xcd_pkg;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;

  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_PENDING  = 2'd1;
  localparam logic [1:0] ST_COMPLETE = 2'd2;
  localparam logic [1:0] ST_FAILSAFE = 2'd3;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 2'd1;

  localparam int TIMEOUT_W = 24;
  localparam logic [7:0]           START_RESET   = 8'h2A;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd500000;

  // frame layout: start byte, 16 payload bytes, checksum byte
  localparam int PAYLOAD_LEN = 16;
  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] POS_IDLE         = 5'd0;
  localparam logic [POS_W-1:0] POS_FIRST        = 5'd1;
  localparam logic [POS_W-1:0] POS_LAST_PAYLOAD = 5'd16;

  localparam int CMP_W = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_TICK = 2'd1,
    KIND_POLL = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]           start_value;
    logic [TIMEOUT_W-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  poll_status;
    logic        frame_accepted;
    logic        checksum_bad;
    logic [31:0] roll_bits;
    logic [31:0] pitch_bits;
    logic [31:0] yaw_bits;
    logic [31:0] thrust_bits;
  } result_t;

endpackage

// ===== sv/xcd_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcd channels: valid/ready interfaces of the command deframer
// input item channel, result channel and config write channel
// ----------------------------------------------------------------------------
interface xcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface xcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  poll_status;
  logic        frame_accepted;
  logic        checksum_bad;
  logic [31:0] roll_bits;
  logic [31:0] pitch_bits;
  logic [31:0] yaw_bits;
  logic [31:0] thrust_bits;

  modport source (output valid, output poll_status, output frame_accepted,
                  output checksum_bad, output roll_bits, output pitch_bits,
                  output yaw_bits, output thrust_bits, input ready);
  modport sink (input valid, input poll_status, input frame_accepted,
                input checksum_bad, input roll_bits, input pitch_bits,
                input yaw_bits, input thrust_bits, output ready);
endinterface

interface xcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/xcd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcd_front: input stage of the command deframer
// takes input beats, decodes the op into an item kind and registers the item
// ----------------------------------------------------------------------------
module xcd_front (
  input  logic           clk,
  input  logic           rst_n,
  xcd_in_if.sink         in_ch,
  output logic           item_valid,
  input  logic           item_ready,
  output xcd_pkg::item_t item
);
  import xcd_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  kind_t kind;
  logic  take;

  always_comb begin
    unique case (in_ch.op)
      OP_BYTE: kind = KIND_BYTE;
      OP_TICK: kind = KIND_TICK;
      OP_POLL: kind = KIND_POLL;
      default: kind = KIND_NONE;
    endcase
  end

  assign in_ch.ready = !valid_r || item_ready;
  assign take = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt = item_r;
    if (take) begin
      valid_nxt = 1'b1;
      item_nxt.kind = kind;
      item_nxt.data = in_ch.rx_byte;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item = item_r;

endmodule

// ===== sv/xcd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcd_queue: short item queue between decoder and executor
// two-entry fifo, ready depends only on its own fill level
// ----------------------------------------------------------------------------
module xcd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  xcd_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output xcd_pkg::item_t rd_item
);
  import xcd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = count_r != CNT_W'(QUEUE_DEPTH);
  assign rd_valid = count_r != '0;
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;
  assign rd_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ===== sv/xcd_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcd_exec: frame tracker, command store and poll logic
// applies one item per cycle while out_ch does not stall and registers its result beat
// ----------------------------------------------------------------------------
module xcd_exec #(
  parameter int TICK_COUNTER_WIDTH = 24
) (
  input  logic           clk,
  input  logic           rst_n,
  input  xcd_pkg::cfg_t  cfg,
  input  logic           item_valid,
  output logic           item_ready,
  input  xcd_pkg::item_t item,
  xcd_out_if.source      out_ch
);
  import xcd_pkg::*;

  localparam int PAY_IDX_W = $clog2(PAYLOAD_LEN);
  localparam logic [TICK_COUNTER_WIDTH-1:0] TICK_MAX = '1;

  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [7:0]                    xor_r, xor_nxt;
  logic [7:0]                    payload_r [PAYLOAD_LEN];
  logic [31:0]                   cmd_r [4];
  logic [31:0]                   cmd_nxt [4];
  logic                          flag_r, flag_nxt;
  logic [TICK_COUNTER_WIDTH-1:0] ticks_r, ticks_nxt;
  logic                          out_valid_r, out_valid_nxt;
  result_t                       res_r, res_nxt;
  logic                          pop;
  logic                          pay_we;
  logic [PAY_IDX_W-1:0]          pay_idx;
  logic                          timed_out;

  assign item_ready = !out_valid_r || out_ch.ready;
  assign pop = item_valid && item_ready;
  assign timed_out = CMP_W'(ticks_r) > CMP_W'(cfg.timeout_ticks);
  assign pay_idx = PAY_IDX_W'(pos_r - POS_FIRST);

  always_comb begin
    pos_nxt = pos_r;
    xor_nxt = xor_r;
    flag_nxt = flag_r;
    ticks_nxt = ticks_r;
    for (int k = 0; k < 4; k++) begin
      cmd_nxt[k] = cmd_r[k];
    end
    pay_we = 1'b0;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (pop) begin
      out_valid_nxt = 1'b1;
      res_nxt.poll_status = ST_NONE;
      res_nxt.frame_accepted = 1'b0;
      res_nxt.checksum_bad = 1'b0;
      unique case (item.kind)
        KIND_BYTE: begin
          if (pos_r == POS_IDLE) begin
            if (item.data == cfg.start_value) begin
              pos_nxt = POS_FIRST;
              xor_nxt = '0;
            end
          end else if (pos_r <= POS_LAST_PAYLOAD) begin
            pay_we = 1'b1;
            xor_nxt = xor_r ^ item.data;
            pos_nxt = POS_W'(pos_r + 1'b1);
          end else begin
            // checksum beat closes the frame either way
            pos_nxt = POS_IDLE;
            if (item.data == xor_r) begin
              for (int k = 0; k < 4; k++) begin
                cmd_nxt[k] = {payload_r[4*k+3], payload_r[4*k+2],
                              payload_r[4*k+1], payload_r[4*k]};
              end
              flag_nxt = 1'b1;
              ticks_nxt = '0;
              res_nxt.frame_accepted = 1'b1;
            end else begin
              res_nxt.checksum_bad = 1'b1;
            end
          end
        end
        KIND_TICK: begin
          if (ticks_r != TICK_MAX) begin
            ticks_nxt = TICK_COUNTER_WIDTH'(ticks_r + 1'b1);
          end
        end
        KIND_POLL: begin
          priority if (timed_out) begin
            flag_nxt = 1'b0;
            for (int k = 0; k < 4; k++) begin
              cmd_nxt[k] = '0;
            end
            res_nxt.poll_status = ST_FAILSAFE;
          end else if (flag_r) begin
            flag_nxt = 1'b0;
            res_nxt.poll_status = ST_COMPLETE;
          end else begin
            res_nxt.poll_status = ST_PENDING;
          end
        end
        KIND_NONE: begin
        end
        default: begin
        end
      endcase
      res_nxt.roll_bits = cmd_nxt[0];
      res_nxt.pitch_bits = cmd_nxt[1];
      res_nxt.yaw_bits = cmd_nxt[2];
      res_nxt.thrust_bits = cmd_nxt[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_IDLE;
      xor_r <= '0;
      flag_r <= 1'b0;
      ticks_r <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        cmd_r[k] <= '0;
      end
    end else begin
      pos_r <= pos_nxt;
      xor_r <= xor_nxt;
      flag_r <= flag_nxt;
      ticks_r <= ticks_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < 4; k++) begin
        cmd_r[k] <= cmd_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (pay_we) begin
      payload_r[pay_idx] <= item.data;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.poll_status = res_r.poll_status;
  assign out_ch.frame_accepted = res_r.frame_accepted;
  assign out_ch.checksum_bad = res_r.checksum_bad;
  assign out_ch.roll_bits = res_r.roll_bits;
  assign out_ch.pitch_bits = res_r.pitch_bits;
  assign out_ch.yaw_bits = res_r.yaw_bits;
  assign out_ch.thrust_bits = res_r.thrust_bits;

endmodule

// ===== sv/xor_checked_command_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_command_deframer_top: start-byte framed command receiver
//
// in_ch carries one item per beat: a received byte, a time tick or a status
// poll. out_ch returns exactly one result beat per item, in order: the poll
// status, frame accepted / checksum bad flags and the four command words
// (roll, pitch, yaw, thrust) as they stand after that item.
// cfg_ch writes start_value (index 0) and timeout_ticks (index 1); it is
// always ready and should only be used while no item is in flight.
// Throughput is one item per cycle while out_ch does not stall, set by the
// per-item update in the executor. From input beat to result beat an item
// passes the decode register, the two-entry queue and the result register.
// When out_ch stalls the result register holds, the queue fills and in_ch
// drops ready after the queue and decode register are full.
// Reset (rst_n low, synchronous) restores the config defaults, clears the
// frame position, flag, tick counter and command words and empties all beats.
// ----------------------------------------------------------------------------
module xor_checked_command_deframer_top #(
  parameter int TICK_COUNTER_WIDTH = 24
) (
  input logic       clk,
  input logic       rst_n,
  xcd_in_if.sink    in_ch,
  xcd_out_if.source out_ch,
  xcd_cfg_if.sink   cfg_ch
);
  import xcd_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  dec_valid, dec_ready;
  item_t dec_item;
  logic  q_valid, q_ready;
  item_t q_item;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_IDX_START) begin
        cfg_nxt.start_value = cfg_ch.data[7:0];
      end else if (cfg_ch.index == CFG_IDX_TIMEOUT) begin
        cfg_nxt.timeout_ticks = cfg_ch.data[TIMEOUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_value <= START_RESET;
      cfg_r.timeout_ticks <= TIMEOUT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  xcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_valid (dec_valid),
    .item_ready (dec_ready),
    .item       (dec_item)
  );

  xcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (dec_valid),
    .wr_ready (dec_ready),
    .wr_item  (dec_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  xcd_exec #(
    .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
  ) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_ch     (out_ch)
  );

endmodule
